// File: sv/ccs_pkg.sv
// Shared widths, types, codes and helpers for the conic curve stepper.
`timescale 1ns / 1ps

package ccs_pkg;

	localparam int COORD_BITS = 13;
	localparam int COEF_BITS  = 24;
	localparam int ACC_BITS   = 48;
	localparam int POS_BITS   = COORD_BITS + 1;
	localparam int PIX_BITS   = COORD_BITS + 2;
	localparam int PROD_BITS  = COEF_BITS + COORD_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [COORD_BITS-1:0] ucoord_t;
	typedef logic        [COEF_BITS-1:0]  coef_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;
	typedef logic        [ACC_BITS-1:0]   uacc_t;
	typedef logic signed [POS_BITS-1:0]   pos_t;
	typedef logic signed [PIX_BITS-1:0]   pix_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic        [1:0]            cnt_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_STEP = 1'b1
	} action_t;

	// End margin and hit count for a closed loop and for an open arc
	localparam cnt_t MARGIN_LOOP = 2'd1;
	localparam cnt_t MARGIN_OPEN = 2'd3;

	function automatic uacc_t acc_mag(input acc_t v);
		uacc_t r;
		if (v[ACC_BITS-1]) begin
			r = uacc_t'(-v);
		end else begin
			r = uacc_t'(v);
		end
		return r;
	endfunction

endpackage

// File: sv/conic_curve_stepper.sv
// Eight-neighbour conic curve stepper: one pixel per step request while a curve runs.
`timescale 1ns / 1ps

// A step request passes the input register and then the output register before its
//   pixel is on the outputs; load requests give no result.
// Throughput: one request per cycle; a step stalls only while the output register
//   holds a pixel that is not taken. The step logic is a single pass of adds,
//   magnitudes and compares between the input register and the state/output.
// A load spends two 25x13 multiplies that seed the gradients in the same pass.
// Reset (arst_n low, asynchronous): idle, both registers empty, no curve loaded.
module conic_curve_stepper (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  ccs_pkg::coord_t  start_x,
	input  ccs_pkg::coord_t  start_y,
	input  ccs_pkg::coord_t  end_x,
	input  ccs_pkg::coord_t  end_y,
	input  logic             clockwise,
	input  ccs_pkg::coef_t   coef_a,
	input  ccs_pkg::coef_t   coef_b,
	input  ccs_pkg::ucoord_t centre_x,
	input  ccs_pkg::ucoord_t centre_y,
	output logic             out_valid,
	input  logic             out_ready,
	output ccs_pkg::pix_t    pixel_x,
	output ccs_pkg::pix_t    pixel_y,
	output logic             last
);
	import ccs_pkg::*;

	// Input register
	logic    valid_s1;
	action_t action_s1;
	coord_t  start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic    clockwise_s1;
	coef_t   coef_a_s1, coef_b_s1;
	ucoord_t centre_x_s1, centre_y_s1;

	// Curve state
	logic    running_q;
	pos_t    cur_x_q, cur_y_q;
	acc_t    grad_x_q, grad_y_q, err_q;
	cnt_t    hits_q, margin_q;
	coord_t  end_x_q, end_y_q;
	logic    cw_q;
	coef_t   a_q, b_q;
	ucoord_t cx_q, cy_q;

	// Output register
	logic    out_valid_q;
	pix_t    pixel_x_q, pixel_y_q;
	logic    last_q;

	logic    is_step, emit, advance;

	// Load datapath
	prod_t   prod_x, prod_y;
	acc_t    grad_x_load, grad_y_load;
	logic    coef_zero;
	cnt_t    margin_load;

	// Step datapath
	acc_t    a_acc, b_acc, two_a, two_b;
	logic    neg_dx, neg_dy;
	acc_t    term_x, term_y, fx, fy, fxy;
	uacc_t   mag_x, mag_y, mag_xy;
	logic    move_x, move_y;
	acc_t    err_next;
	pos_t    step_x, step_y, cur_x_next, cur_y_next;
	acc_t    grad_x_next, grad_y_next;
	pix_t    pix_x_d, pix_y_d, ex, ey, m_ext;
	logic    near;
	cnt_t    hits_dec;
	logic    done;

	// Handshake: a step that emits waits for room in the output register;
	// loads and idle steps drain freely.
	assign is_step  = (action_s1 == ACT_STEP);
	assign emit     = valid_s1 && is_step && running_q;
	assign advance  = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Seed gradients 2*a*x and 2*b*y from the start point
	always_comb begin
		prod_x      = prod_t'($signed({1'b0, coef_a_s1})) * prod_t'(start_x_s1);
		prod_y      = prod_t'($signed({1'b0, coef_b_s1})) * prod_t'(start_y_s1);
		grad_x_load = acc_t'(prod_x) <<< 1;
		grad_y_load = acc_t'(prod_y) <<< 1;
		coef_zero   = (coef_a_s1 == '0) || (coef_b_s1 == '0);
		// Start on the end point means a full loop: tight margin, single hit
		margin_load = (start_x_s1 == end_x_s1 && start_y_s1 == end_y_s1) ?
			MARGIN_LOOP : MARGIN_OPEN;
	end

	// One step: try the x move, the y move and the diagonal, keep the one
	// with the smallest error magnitude (ties go to diagonal, then y).
	always_comb begin
		a_acc  = acc_t'(a_q);
		b_acc  = acc_t'(b_q);
		two_a  = a_acc <<< 1;
		two_b  = b_acc <<< 1;
		// Direction of each move follows the sign of the other gradient
		neg_dx = cw_q ^ grad_y_q[ACC_BITS-1];
		neg_dy = ~(cw_q ^ grad_x_q[ACC_BITS-1]);
		term_x = neg_dx ? -grad_x_q : grad_x_q;
		term_y = neg_dy ? -grad_y_q : grad_y_q;
		fx     = err_q + term_x + a_acc;
		fy     = err_q + term_y + b_acc;
		fxy    = fx + fy - err_q;
		mag_x  = acc_mag(fx);
		mag_y  = acc_mag(fy);
		mag_xy = acc_mag(fxy);

		if (mag_xy <= mag_x && mag_xy <= mag_y) begin
			move_x   = 1'b1;
			move_y   = 1'b1;
			err_next = fxy;
		end else if (mag_y <= mag_x) begin
			move_x   = 1'b0;
			move_y   = 1'b1;
			err_next = fy;
		end else begin
			move_x   = 1'b1;
			move_y   = 1'b0;
			err_next = fx;
		end

		step_x     = !move_x ? '0 : (neg_dx ? '1 : pos_t'(1));
		step_y     = !move_y ? '0 : (neg_dy ? '1 : pos_t'(1));
		cur_x_next = cur_x_q + step_x;
		cur_y_next = cur_y_q + step_y;

		grad_x_next = grad_x_q;
		if (move_x) begin
			grad_x_next = neg_dx ? grad_x_q - two_a : grad_x_q + two_a;
		end
		grad_y_next = grad_y_q;
		if (move_y) begin
			grad_y_next = neg_dy ? grad_y_q - two_b : grad_y_q + two_b;
		end

		// Pixel at the position before the move; frame y runs downward
		pix_x_d = pix_t'({2'b00, cx_q}) + pix_t'(cur_x_q);
		pix_y_d = pix_t'({2'b00, cy_q}) - pix_t'(cur_y_q);

		// Count a hit when the new position lies inside the end margin
		ex       = pix_t'(cur_x_next) - pix_t'(end_x_q);
		ey       = pix_t'(cur_y_next) - pix_t'(end_y_q);
		m_ext    = pix_t'(margin_q);
		near     = (ex < m_ext) && (ex > -m_ext) && (ey < m_ext) && (ey > -m_ext);
		hits_dec = hits_q - cnt_t'(1);
		done     = near && (hits_dec == '0);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			running_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance && !is_step) begin
				running_q <= !coef_zero;
			end else if (advance && emit && done) begin
				running_q <= 1'b0;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: input capture, curve state and result
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1    <= action_t'(action);
			start_x_s1   <= start_x;
			start_y_s1   <= start_y;
			end_x_s1     <= end_x;
			end_y_s1     <= end_y;
			clockwise_s1 <= clockwise;
			coef_a_s1    <= coef_a;
			coef_b_s1    <= coef_b;
			centre_x_s1  <= centre_x;
			centre_y_s1  <= centre_y;
		end

		if (advance && !is_step) begin
			// Latch the curve; the walk state matters only once running
			end_x_q  <= end_x_s1;
			end_y_q  <= end_y_s1;
			cw_q     <= clockwise_s1;
			a_q      <= coef_a_s1;
			b_q      <= coef_b_s1;
			cx_q     <= centre_x_s1;
			cy_q     <= centre_y_s1;
			cur_x_q  <= pos_t'(start_x_s1);
			cur_y_q  <= pos_t'(start_y_s1);
			grad_x_q <= grad_x_load;
			grad_y_q <= grad_y_load;
			err_q    <= '0;
			margin_q <= margin_load;
			hits_q   <= margin_load;
		end else if (advance && emit) begin
			cur_x_q   <= cur_x_next;
			cur_y_q   <= cur_y_next;
			grad_x_q  <= grad_x_next;
			grad_y_q  <= grad_y_next;
			err_q     <= err_next;
			if (near) begin
				hits_q <= hits_dec;
			end
			pixel_x_q <= pix_x_d;
			pixel_y_q <= pix_y_d;
			last_q    <= done;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign last      = last_q;

endmodule
